>>> src/dpcl_pkg.sv
package dpcl_pkg;

    localparam int unsigned CUR_W    = 16;
    localparam int unsigned CODE_W   = 8;
    localparam int unsigned PROD_W   = 34;
    localparam int unsigned DEN_W    = 20;
    localparam int unsigned NUM_W    = 30;
    localparam int unsigned FINE_SH  = 14;
    localparam int unsigned DIV_BITS = 8;

    // Stage map: check, reciprocal multiply, coarse clamp, divisor, saturation,
    // then one restoring divide step per stage, MSB first.
    localparam int unsigned STG_MUL  = 1;
    localparam int unsigned STG_CRS  = 2;
    localparam int unsigned STG_DEN  = 3;
    localparam int unsigned STG_SAT  = 4;
    localparam int unsigned STG_DIV0 = 5;
    localparam int unsigned NSTG     = STG_DIV0 + DIV_BITS;

    localparam logic [2:0] ADDR_MIN = 3'd0;
    localparam logic [2:0] ADDR_MAX = 3'd4;

    localparam logic [CUR_W-1:0]  MIN_RST   = 16'd10;
    localparam logic [CUR_W-1:0]  MAX_RST   = 16'd5000;
    // floor(cur * 128 / 3125) == (cur * RECIP) >> 25 for cur < 8192
    localparam logic [20:0]       RECIP     = 21'd1374390;
    localparam int unsigned       RECIP_SH  = 25;
    localparam int unsigned       SMALL_W   = 13;
    // at or above this request the coarse code clamps to full scale
    localparam logic [CUR_W-1:0]  BIG_CUR   = 16'd6250;
    localparam logic [11:0]       SCALE_DEN = 12'd3125;
    localparam logic [CODE_W-1:0] CODE_MAX  = 8'd255;
    localparam logic [CODE_W-1:0] CODE_MIN  = 8'd1;

    typedef struct packed {
        logic              acc;
        logic              big;
        logic [CUR_W-1:0]  cur;
        logic [PROD_W-1:0] prod;
        logic [CODE_W-1:0] coarse;
        logic [DEN_W-1:0]  den;
        logic [NUM_W-1:0]  rem;
        logic [CODE_W-1:0] quo;
        logic              sat;
    } pl_t;

endpackage

>>> src/dual_pot_current_limit_split.sv
// Pipeline: one register per stage, from the input check to the last divide step;
// m_tvalid rises when a request reaches the last stage.
// Throughput: one item per cycle unless the output stalls; one restoring divide
// step per stage for the fine code, and every stage holds under back-pressure.
// Reset: aresetn synchronous, active low; empties the pipeline and loads the lower
// limit 10 mA and the upper limit 5000 mA.
module dual_pot_current_limit_split (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] req_ma
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] coarse_pot, [15:8] fine_pot
    output logic        m_tuser    // [0] accepted
);

    localparam int unsigned NS = dpcl_pkg::NSTG;

    logic [dpcl_pkg::CUR_W-1:0] min_reg;
    logic [dpcl_pkg::CUR_W-1:0] max_reg;
    logic                       cfg_wr;

    logic           vld_reg [NS];
    dpcl_pkg::pl_t  dat_reg [NS];
    dpcl_pkg::pl_t  dat_next [NS];
    logic           rdy [NS+1];

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= dpcl_pkg::MIN_RST;
            max_reg <= dpcl_pkg::MAX_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                dpcl_pkg::ADDR_MIN[2]: min_reg <= pwdata[15:0];
                dpcl_pkg::ADDR_MAX[2]: max_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            dpcl_pkg::ADDR_MIN[2]: prdata = {16'd0, min_reg};
            dpcl_pkg::ADDR_MAX[2]: prdata = {16'd0, max_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // stage handshake
    always_comb begin
        rdy[NS] = m_tready;
        for (int k = NS - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign s_tready = rdy[0];

    always_comb begin
        logic [dpcl_pkg::NUM_W-1:0] shd;
        logic [dpcl_pkg::NUM_W-1:0] lim;
        logic [2:0]                 b;
        dat_next[0]      = '0;
        dat_next[0].cur  = s_tdata;
        dat_next[0].acc  = (s_tdata >= min_reg) && (s_tdata <= max_reg);
        dat_next[0].big  = s_tdata >= dpcl_pkg::BIG_CUR;
        shd = '0;
        lim = '0;
        b   = '0;
        for (int k = 1; k < NS; k++) begin
            dat_next[k] = dat_reg[k-1];
            if (k == dpcl_pkg::STG_MUL) begin
                dat_next[k].prod =
                    dpcl_pkg::PROD_W'(dat_reg[k-1].cur[dpcl_pkg::SMALL_W-1:0]) *
                    dpcl_pkg::PROD_W'(dpcl_pkg::RECIP);
            end else if (k == dpcl_pkg::STG_CRS) begin
                if (dat_reg[k-1].big) begin
                    dat_next[k].coarse = dpcl_pkg::CODE_MAX;
                end else if (dat_reg[k-1].prod[dpcl_pkg::PROD_W-1:dpcl_pkg::RECIP_SH]
                             == '0) begin
                    dat_next[k].coarse = dpcl_pkg::CODE_MIN;
                end else begin
                    dat_next[k].coarse =
                        dat_reg[k-1].prod[dpcl_pkg::RECIP_SH+7:dpcl_pkg::RECIP_SH];
                end
            end else if (k == dpcl_pkg::STG_DEN) begin
                dat_next[k].den = dpcl_pkg::DEN_W'(dat_reg[k-1].coarse) *
                                  dpcl_pkg::DEN_W'(dpcl_pkg::SCALE_DEN);
                dat_next[k].rem = {dat_reg[k-1].cur, dpcl_pkg::FINE_SH'(0)};
            end else if (k == dpcl_pkg::STG_SAT) begin
                lim = {2'b00, dat_reg[k-1].den, 8'd0};
                dat_next[k].sat = dat_reg[k-1].rem >= lim;
                dat_next[k].quo = '0;
            end else begin
                b   = 3'(dpcl_pkg::DIV_BITS - 1 - (k - dpcl_pkg::STG_DIV0));
                shd = dpcl_pkg::NUM_W'({10'd0, dat_reg[k-1].den} << b);
                if (dat_reg[k-1].rem >= shd) begin
                    dat_next[k].rem    = dat_reg[k-1].rem - shd;
                    dat_next[k].quo[b] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NS; k++) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                vld_reg[k] <= (k == 0) ? s_tvalid : vld_reg[k == 0 ? 0 : k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NS; k++) begin
            if (rdy[k]) begin
                dat_reg[k] <= dat_next[k];
            end
        end
    end

    always_comb begin
        m_tvalid = vld_reg[NS-1];
        m_tuser  = dat_reg[NS-1].acc;
        if (!dat_reg[NS-1].acc) begin
            m_tdata = '0;
        end else begin
            m_tdata[7:0]  = dat_reg[NS-1].coarse;
            m_tdata[15:8] = dat_reg[NS-1].sat ? dpcl_pkg::CODE_MAX : dat_reg[NS-1].quo;
        end
    end

endmodule

>>> src/dpcl_checker.sv
module dpcl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        pready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 16'd0)
        else $error("rejected result carries non-zero codes");

    a_coarse_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[7:0] != 8'd0)
        else $error("accepted result with zero coarse code");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind dual_pot_current_limit_split dpcl_checker u_dpcl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .pready   (pready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int unsigned COARSE_GAIN = 128;
    localparam int unsigned FINE_GAIN   = 16384;
    localparam int unsigned POT_SCALE   = 3125;
    localparam int unsigned MAX_IDLE    = 17;
    localparam int unsigned DRAIN_WAIT  = 24;

    typedef struct packed {
        logic                        accepted;
        logic [dpcl_pkg::CODE_W-1:0] coarse;
        logic [dpcl_pkg::CODE_W-1:0] fine;
    } pot_codes_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [15:0] req_ma
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [7:0] coarse_pot, [15:8] fine_pot
    logic        m_tuser;         // [0] accepted

    pot_codes_t                 pending_codes[$];
    logic [dpcl_pkg::CUR_W-1:0] lim_min = dpcl_pkg::MIN_RST;
    logic [dpcl_pkg::CUR_W-1:0] lim_max = dpcl_pkg::MAX_RST;
    bit                         tx_idle_on = 1'b1;
    bit                         rx_idle_on = 1'b1;
    int                         errors = 0;

    dual_pot_current_limit_split u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    function automatic pot_codes_t predict_pot_codes(logic [dpcl_pkg::CUR_W-1:0] cur);
        pot_codes_t  codes;
        logic [63:0] crs;
        logic [63:0] fn;
        codes = '0;
        if (cur < lim_min || cur > lim_max)
            return codes;
        crs = (64'(cur) * COARSE_GAIN) / POT_SCALE;
        if (crs > 64'(dpcl_pkg::CODE_MAX))
            crs = 64'(dpcl_pkg::CODE_MAX);
        if (crs == 0)
            crs = 1;
        fn = (64'(cur) * FINE_GAIN) / (64'(POT_SCALE) * crs);
        if (fn > 64'(dpcl_pkg::CODE_MAX))
            fn = 64'(dpcl_pkg::CODE_MAX);
        codes.accepted = 1'b1;
        codes.coarse   = crs[dpcl_pkg::CODE_W-1:0];
        codes.fine     = fn[dpcl_pkg::CODE_W-1:0];
        return codes;
    endfunction

    task automatic apb_write(input logic [2:0] addr,
                             input logic [dpcl_pkg::CUR_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'h0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == dpcl_pkg::ADDR_MIN)
            lim_min = value;
        else
            lim_max = value;
    endtask

    task automatic apb_check_read(input logic [2:0] addr,
                                  input logic [dpcl_pkg::CUR_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {16'h0, want}) begin
            $error("prdata at %0d: expected %0h, got %0h", addr, want, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // let the pipeline empty before touching the limits
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic set_limits(input logic [dpcl_pkg::CUR_W-1:0] lo,
                              input logic [dpcl_pkg::CUR_W-1:0] hi);
        wait_drained();
        apb_write(dpcl_pkg::ADDR_MIN, lo);
        apb_write(dpcl_pkg::ADDR_MAX, hi);
        apb_check_read(dpcl_pkg::ADDR_MIN, lo);
        apb_check_read(dpcl_pkg::ADDR_MAX, hi);
    endtask

    task automatic send_request(input logic [dpcl_pkg::CUR_W-1:0] cur);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cur;
        do @(posedge aclk); while (!s_tready);
        pending_codes.push_back(predict_pot_codes(cur));
    endtask

    function automatic logic [dpcl_pkg::CUR_W-1:0] pick_current();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6 && lim_min <= lim_max)
            return dpcl_pkg::CUR_W'($urandom_range(lim_max, lim_min));
        if (sel == 6)
            return dpcl_pkg::CUR_W'(lim_min + $urandom_range(0, 2) - 1);
        if (sel == 7)
            return dpcl_pkg::CUR_W'(lim_max + $urandom_range(0, 2) - 1);
        if (sel == 8)
            return dpcl_pkg::CUR_W'($urandom_range(0, 300));
        return dpcl_pkg::CUR_W'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic test_reset_limits();
        logic [dpcl_pkg::CUR_W-1:0] pts[$];
        pts = '{0, 9, 10, 11, 24, 25, 26, 49, 50, 1000, 3125, 4999, 5000, 5001, 6249,
                6250, 32768, 16'hFFFF};
        foreach (pts[i])
            send_request(pts[i]);
        wait_drained();
        apb_check_read(dpcl_pkg::ADDR_MIN, dpcl_pkg::MIN_RST);
        apb_check_read(dpcl_pkg::ADDR_MAX, dpcl_pkg::MAX_RST);
    endtask

    task automatic test_full_range();
        logic [dpcl_pkg::CUR_W-1:0] pts[$];
        pts = '{0, 1, 2, 24, 25, 48, 6224, 6225, 6249, 6250, 6251, 8191, 8192,
                16'h5555, 16'hAAAA, 16'h7FFF, 16'hFFFE, 16'hFFFF};
        set_limits(16'h0000, 16'hFFFF);
        foreach (pts[i])
            send_request(pts[i]);
    endtask

    task automatic test_empty_window();
        logic [dpcl_pkg::CUR_W-1:0] pts[$];
        pts = '{0, 49, 50, 51, 75, 99, 100, 101, 16'hFFFF};
        set_limits(16'd100, 16'd50);
        foreach (pts[i])
            send_request(pts[i]);
        set_limits(16'hFFFF, 16'hFFFF);
        send_request(16'hFFFE);
        send_request(16'hFFFF);
        set_limits(16'h0000, 16'h0000);
        send_request(16'h0000);
        send_request(16'h0001);
    endtask

    task automatic test_random_traffic(input int n_items);
        logic [dpcl_pkg::CUR_W-1:0] lo_set[$];
        logic [dpcl_pkg::CUR_W-1:0] hi_set[$];
        logic [dpcl_pkg::CUR_W-1:0] lo;
        logic [dpcl_pkg::CUR_W-1:0] hi;
        int per_phase;
        lo_set = '{0, 10, 6250, 0, 25, 0, 0, 0};
        hi_set = '{16'hFFFF, 5000, 16'hFFFF, 6250, 25, 0, 0, 0};
        per_phase = n_items / lo_set.size();
        foreach (lo_set[p]) begin
            lo = lo_set[p];
            hi = hi_set[p];
            if (p >= 5) begin
                lo = dpcl_pkg::CUR_W'($urandom_range(0, 16'hFFFF));
                hi = (p == 7) ? dpcl_pkg::CUR_W'($urandom_range(0, 16'hFFFF))
                              : dpcl_pkg::CUR_W'($urandom_range(16'hFFFF, lo));
            end
            set_limits(lo, hi);
            for (int i = 0; i < per_phase; i++) begin
                if (i % 64 == 0) begin
                    tx_idle_on = ($urandom_range(0, 3) != 0);
                    rx_idle_on = ($urandom_range(0, 3) != 0);
                end
                if (i == per_phase / 2)
                    wait_drained();
                send_request(pick_current());
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_limits();
        test_full_range();
        test_empty_window();
        test_random_traffic(1860);
        wait_drained();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int         stall;
        pot_codes_t want;
        pot_codes_t got;
        wait (aresetn);
        forever begin
            stall = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.accepted = m_tuser;
            got.coarse   = m_tdata[7:0];
            got.fine     = m_tdata[15:8];
            if (pending_codes.size() == 0) begin
                $error("unexpected result transfer: tdata %0h tuser %0b", m_tdata, m_tuser);
                errors++;
            end else begin
                want = pending_codes.pop_front();
                if (got.accepted !== want.accepted) begin
                    $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
                    errors++;
                end
                if (got.coarse !== want.coarse) begin
                    $error("coarse_pot: expected %0d, got %0d", want.coarse, got.coarse);
                    errors++;
                end
                if (got.fine !== want.fine) begin
                    $error("fine_pot: expected %0d, got %0d", want.fine, got.fine);
                    errors++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
